[rtl/core/assert_macros.svh]
// Assertion macros shared by the animator core modules.
// Include guarded; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check that holds outside reset.
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication check: the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/lmsa_pkg.sv]
// Shared types and constants for the status LED frame animator.
// No dependencies.
`timescale 1ns / 1ps
package lmsa_pkg;
   localparam int ROWS        = 8;
   localparam int COLS        = 12;
   localparam int TW          = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_STARTUP  = 2'd1;
   localparam logic [1:0] MODE_SHUTDOWN = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   localparam logic [1:0] ANIM_NONE     = 2'd0;
   localparam logic [1:0] ANIM_STARTUP  = 2'd1;
   localparam logic [1:0] ANIM_SHUTDOWN = 2'd2;

   localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
   localparam logic [1:0] LINK_CONNECTING   = 2'd1;
   localparam logic [1:0] LINK_CONNECTED    = 2'd2;

   localparam logic [2:0] REG_BAR0     = 3'd0;
   localparam logic [2:0] REG_BAR4     = 3'd4;
   localparam logic [2:0] REG_SENSOR   = 3'd5;
   localparam logic [2:0] REG_STARTUP  = 3'd6;
   localparam logic [2:0] REG_SHUTDOWN = 3'd7;

   // Queued command after classification.
   typedef struct packed {
      logic [1:0]  mode;
      logic [TW-1:0] now_ms;
      logic signed [7:0] sig;
      logic [1:0]  link;
      logic signed [11:0] temp;
      logic [10:0] hum;
   } cmd_type;
endpackage

[rtl/core/lmsa_front.sv]
// Front end: accepts stream transactions, drops unused modes, queues commands.
// Depends on lmsa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module lmsa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lmsa_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_ready,
   output lmsa_pkg::cmd_type q_cmd
);
   import lmsa_pkg::*;
   `include "assert_macros.svh"

   cmd_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop, keep;

   assign in_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign keep = (in_cmd.mode != MODE_UNUSED);
   assign push = in_valid && in_ready && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cmd = mem_ff[rp_ff];

   // Pointer and count update.
   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_cmd;
   end

   `CHK_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= 2'(QUEUE_DEPTH), "queue overflow")
   `CHK_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1,
      "queue count lost a push")
   `CHK_ALWAYS(a_ptr_sync, clock, reset, (cnt_ff == 2'd1) == (wp_ff != rp_ff),
      "queue pointers disagree with count")
endmodule

[rtl/core/lmsa_back.sv]
// Back end: frame state, refresh logic, animations and row emission.
// Depends on lmsa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module lmsa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  lmsa_pkg::cmd_type q_cmd,
   input  logic [7:0]        bar_ff [5],
   input  logic [15:0]       sensor_ms,
   input  logic [15:0]       startup_ms,
   input  logic [15:0]       shutdown_ms,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_row,
   output logic [11:0]       out_bits,
   output logic              out_last
);
   import lmsa_pkg::*;
   `include "assert_macros.svh"

   logic [COLS-1:0] frame_ff [ROWS];
   logic [COLS-1:0] frame_in [ROWS];
   logic [TW-1:0] nlink_ff, nlink_in, nt_ff, nt_in, nh_ff, nh_in, lst_ff, lst_in;
   logic [1:0] kind_ff, kind_in;
   logic [6:0] step_ff, step_in;
   logic blink_ff, blink_in;
   logic [2:0] ring_ff, ring_in;
   // Emission: snapshot of frame, row counter.
   logic [COLS-1:0] snap_ff [ROWS];
   logic busy_ff, busy_in;
   logic [2:0] row_ff, row_in;
   logic emit;

   logic [TW-1:0] el;
   logic [3:0] sr;
   logic [3:0] sc;
   logic [3:0] cc;
   logic [2:0] g;
   logic signed [7:0] s;
   logic [2:0] gm;

   assign q_ready = !busy_ff || (out_ready && row_ff == 3'd7);
   assign out_valid = busy_ff;
   assign out_row = row_ff;
   assign out_bits = snap_ff[row_ff];
   assign out_last = (row_ff == 3'd7);

   assign el = q_cmd.now_ms - lst_ff;
   // Snake position: row = step/12 as (step * 171) >> 11, exact for steps 0..95.
   always_comb begin
      sr = 4'((15'(step_ff) * 15'd171) >> 11);
      sc = 4'(step_ff - 7'(sr) * 7'd12);
      cc = sr[0] ? 4'd11 - sc : sc;
   end
   assign g = ring_ff;
   assign gm = 3'd7 - g;
   assign s = q_cmd.sig;

   always_comb begin
      frame_in = frame_ff;
      nlink_in = nlink_ff; nt_in = nt_ff; nh_in = nh_ff; lst_in = lst_ff;
      kind_in = kind_ff; step_in = step_ff; blink_in = blink_ff; ring_in = ring_ff;
      emit = 1'b0;
      if (q_valid && q_ready) begin
         if (q_cmd.mode == MODE_STARTUP || q_cmd.mode == MODE_SHUTDOWN) begin
            kind_in = q_cmd.mode;
            step_in = 7'd0;
            lst_in = q_cmd.now_ms;
         end else if (kind_ff == ANIM_STARTUP) begin
            if (step_ff < 7'd96) begin
               if (el >= TW'(startup_ms)) begin
                  frame_in[sr[2:0]][cc] = 1'b1;
                  emit = 1'b1;
               end
            end else if (step_ff < 7'd106) begin
               if (el >= TW'(200)) begin
                  for (int r = 0; r < ROWS; r++) frame_in[r] = {COLS{blink_ff}};
                  blink_in = !blink_ff;
                  emit = 1'b1;
               end
            end else kind_in = ANIM_NONE;
         end else if (kind_ff == ANIM_SHUTDOWN) begin
            if (step_ff == 7'd0) begin
               for (int r = 0; r < ROWS; r++) frame_in[r] = '0;
               emit = 1'b1;
            end else if (step_ff <= 7'd5) begin
               if (el >= TW'(shutdown_ms)) begin
                  frame_in[g] = '1;
                  frame_in[gm] = '1;
                  for (int r = 0; r < ROWS; r++) begin
                     frame_in[r][g] = 1'b1;
                     frame_in[r][4'd11 - {1'b0, g}] = 1'b1;
                  end
                  ring_in = ring_ff + 3'd1;
                  emit = 1'b1;
               end
            end else if (step_ff == 7'd6) begin
               if (el >= TW'(500)) begin
                  for (int r = 0; r < ROWS; r++) frame_in[r] = '0;
                  emit = 1'b1;
               end
            end else if (step_ff == 7'd7) begin
               if (el >= TW'(800)) begin
                  frame_in[2][3] = 1'b1; frame_in[2][4] = 1'b1;
                  frame_in[2][7] = 1'b1; frame_in[2][8] = 1'b1;
                  emit = 1'b1;
               end
            end else begin
               kind_in = ANIM_NONE;
               ring_in = 3'd0;
            end
         end else begin
            emit = 1'b1;
            if (q_cmd.now_ms > nlink_ff) begin
               frame_in[7][0] = 1'b1;
               for (int r = 2; r < 7; r++) frame_in[r][0] = (s >= $signed(bar_ff[r-2]));
               if (s == 8'sd0) begin
                  frame_in[2][0] = 1'b0; frame_in[4][0] = 1'b0; frame_in[6][0] = 1'b0;
               end
               frame_in[6][1] = (q_cmd.link == LINK_CONNECTED);
               frame_in[7][1] = (q_cmd.link == LINK_CONNECTED) ||
                                (q_cmd.link == LINK_CONNECTING);
               nlink_in = q_cmd.now_ms + TW'(300);
            end
            if (q_cmd.now_ms >= nt_ff) begin
               frame_in[7][4] = 1'b0;
               frame_in[6][4] = q_cmd.temp > 12'sd0;
               frame_in[5][4] = q_cmd.temp > 12'sd128;
               frame_in[4][4] = q_cmd.temp > 12'sd256;
               frame_in[3][4] = q_cmd.temp > 12'sd384;
               frame_in[2][4] = q_cmd.temp > 12'sd512;
               nt_in = q_cmd.now_ms + TW'(sensor_ms);
            end
            if (q_cmd.now_ms >= nh_ff) begin
               frame_in[7][5] = q_cmd.hum > 11'd640;
               frame_in[6][5] = q_cmd.hum > 11'd800;
               frame_in[5][5] = q_cmd.hum > 11'd960;
               frame_in[4][5] = q_cmd.hum > 11'd1120;
               frame_in[3][5] = q_cmd.hum > 11'd1280;
               frame_in[2][5] = q_cmd.hum > 11'd1440;
               nh_in = q_cmd.now_ms + TW'(sensor_ms);
            end
         end
         if (emit && kind_ff != ANIM_NONE && q_cmd.mode == MODE_TICK) begin
            step_in = step_ff + 7'd1;
            lst_in = q_cmd.now_ms;
         end
      end
   end

   // Row counter of the emitter.
   always_comb begin
      busy_in = busy_ff;
      row_in = row_ff;
      if (busy_ff && out_ready) begin
         row_in = row_ff + 3'd1;
         if (row_ff == 3'd7) busy_in = 1'b0;
      end
      if (emit) begin
         busy_in = 1'b1;
         row_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) frame_ff[r] <= '0;
         nlink_ff <= '0; nt_ff <= '0; nh_ff <= '0; lst_ff <= '0;
         kind_ff <= ANIM_NONE; step_ff <= '0; blink_ff <= 1'b1; ring_ff <= '0;
         busy_ff <= 1'b0; row_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         nlink_ff <= nlink_in; nt_ff <= nt_in; nh_ff <= nh_in; lst_ff <= lst_in;
         kind_ff <= kind_in; step_ff <= step_in; blink_ff <= blink_in; ring_ff <= ring_in;
         busy_ff <= busy_in; row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) snap_ff <= frame_in;
   end

   `CHK_NEXT(a_emit_row0, clock, reset, emit, busy_ff && row_ff == 3'd0,
      "frame emission did not start at row 0")
   `CHK_ALWAYS(a_step_range, clock, reset, step_ff <= 7'd106, "animation step out of range")
   `CHK_ALWAYS(a_no_double, clock, reset, !(emit && busy_ff && !(out_ready && row_ff == 3'd7)),
      "new frame while previous still emitting")
endmodule

[rtl/core/led_matrix_status_animator_core.sv]
// Row 0 of a frame is presented after the tick passes the queue register and
// the frame snapshot register; the queue stalls while a frame is still emitting.
// Throughput: frames go out one row per cycle while rsp_tready is high; a new
// item is taken only as the last row goes out. A 2-entry queue separates intake.
// Reset: synchronous active high; frame off, registers to defaults, queue empty.
`timescale 1ns / 1ps
module led_matrix_status_animator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [49:2] now_ms, [57:50] signal_strength, [59:58] link_state,
   // [71:60] temperature, [82:72] humidity, [87:83] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] row_index, [14:3] row_bits, [15] zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lmsa_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready;
   logic [7:0] bar_ff [5];
   logic [15:0] sensor_ff, startup_ff, shutdown_ff;
   logic [2:0] row;
   logic [11:0] bits;

   assign in_cmd.mode = req_tdata[1:0];
   assign in_cmd.now_ms = req_tdata[49:2];
   assign in_cmd.sig = req_tdata[57:50];
   assign in_cmd.link = req_tdata[59:58];
   assign in_cmd.temp = req_tdata[71:60];
   assign in_cmd.hum = req_tdata[82:72];
   assign csr_ready = 1'b1;
   assign rsp_tdata = {1'b0, bits, row};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_ff[0] <= 8'hA6; bar_ff[1] <= 8'hB0; bar_ff[2] <= 8'hBA;
         bar_ff[3] <= 8'hC4; bar_ff[4] <= 8'hCE;
         sensor_ff <= 16'd1000; startup_ff <= 16'd30; shutdown_ff <= 16'd400;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SENSOR:   sensor_ff <= csr_data;
            REG_STARTUP:  startup_ff <= csr_data;
            REG_SHUTDOWN: shutdown_ff <= csr_data;
            default:      bar_ff[csr_index] <= csr_data[7:0];
         endcase
      end
   end

   lmsa_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   lmsa_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .bar_ff(bar_ff), .sensor_ms(sensor_ff), .startup_ms(startup_ff),
      .shutdown_ms(shutdown_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_row(row), .out_bits(bits), .out_last(rsp_tlast)
   );
endmodule
